@@ sv/gaussian_pyramid_reduce_top_defines.svh @@
// Assertion macros for the pyramid reduce block.
`ifndef GAUSSIAN_PYRAMID_REDUCE_TOP_DEFINES_SVH
`define GAUSSIAN_PYRAMID_REDUCE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define GPR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define GPR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GPR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define GPR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ sv/gpr_pkg.sv @@
`default_nettype none
package gpr_pkg;

   localparam int PIX_W         = 8;
   localparam int CFG_W         = 12;
   localparam int CSR_ADDR_W    = 1;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAX_HEIGHT    = 2048;
   localparam int ROW_W         = 11;
   localparam int IN_WIDTH_RST  = 640;
   localparam int IN_HEIGHT_RST = 480;
   localparam int MIN_DIM       = 4;
   localparam int LANES         = 4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IN_WIDTH  = 1'b0,
      CSR_IN_HEIGHT = 1'b1
   } csr_index_type;

   // position of a sample within a row or a column of the filter grid
   typedef enum logic [2:0] {
      TAP_NONE      = 3'd0,
      TAP_FIRST     = 3'd1,
      TAP_MID       = 3'd2,
      TAP_LAST_EVEN = 3'd3,
      TAP_LAST_ODD  = 3'd4
   } tap_kind_type;

   function automatic tap_kind_type classify(logic [15:0] pos, logic [15:0] size);
      tap_kind_type k;
      logic [15:0]  mid_top;
      mid_top = (size & 16'hFFFE) - 16'd2;
      if (pos == size - 16'd1) begin
         k = size[0] ? TAP_LAST_ODD : TAP_LAST_EVEN;
      end else if (pos == 16'd2) begin
         k = TAP_FIRST;
      end else if (!pos[0] && pos > 16'd2 && pos <= mid_top) begin
         k = TAP_MID;
      end else begin
         k = TAP_NONE;
      end
      return k;
   endfunction

   // 1-4-6-4-1 with edge taps folded onto the center, truncated by four bits
   function automatic logic [PIX_W-1:0] filter5(tap_kind_type k,
                                                logic [PIX_W-1:0] s4,
                                                logic [PIX_W-1:0] s3,
                                                logic [PIX_W-1:0] s2,
                                                logic [PIX_W-1:0] s1,
                                                logic [PIX_W-1:0] cur);
      logic [PIX_W+3:0] sum;
      case (k)
         TAP_FIRST:
            sum = (12'(s2) * 12'd11) + (12'(s1) << 2) + 12'(cur);
         TAP_MID:
            sum = 12'(s4) + (12'(s3) << 2) + (12'(s2) * 12'd6) + (12'(s1) << 2)
                  + 12'(cur);
         TAP_LAST_EVEN:
            sum = 12'(s3) + (12'(s2) << 2) + (12'(s1) * 12'd11);
         default:
            sum = 12'(s4) + (12'(s3) << 2) + (12'(s2) * 12'd11);
      endcase
      return sum[PIX_W+3:4];
   endfunction

endpackage
`default_nettype wire

@@ sv/gaussian_pyramid_reduce_top.sv @@
// A result passes the vertical stage register, then the result register, before rsp_tvalid.
// Throughput: one pixel per cycle, set by one line memory read and one lane write per cycle;
// req stalls only while the stage and result registers are both full and rsp_tready is low.
// Reset (synchronous, active high): counters, window and valid flags clear, the frame size
// returns to 640 x 480. The line memory is not cleared: every lane that a result uses is
// written earlier in the same frame.
`default_nettype none
`include "gaussian_pyramid_reduce_top_defines.svh"

module gaussian_pyramid_reduce_top #(
   parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input pixel stream
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [gpr_pkg::PIX_W-1:0]     req_tdata,   // [7:0] pixel
   // reduced pixel stream
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [gpr_pkg::PIX_W-1:0]          rsp_tdata,   // [7:0] out_pixel
   output logic                               rsp_tlast,   // frame_end
   output logic [0:0]                         rsp_tuser,   // [0] row_end
   // configuration writes
   input  wire logic                          csr_we,
   input  wire logic [gpr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [gpr_pkg::CFG_W-1:0]     csr_wdata
);
   import gpr_pkg::*;

   localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);  // holds the row length itself
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int HALF    = MAX_WIDTH / 2;         // line memory slots per row
   localparam int SLOT_W  = $clog2(HALF);
   localparam int WORD_W  = LANES * PIX_W;         // one byte lane per stored row

   // Clamp a written row length to 4..MAX_WIDTH.
   function automatic logic [WIDTH_W-1:0] clamp_w(logic [CFG_W-1:0] v);
      logic [WIDTH_W-1:0] r;
      if (int'(v) < MIN_DIM) begin
         r = WIDTH_W'(MIN_DIM);
      end else if (int'(v) > MAX_WIDTH) begin
         r = WIDTH_W'(MAX_WIDTH);
      end else begin
         r = WIDTH_W'(v);
      end
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] clamp_h(logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      if (int'(v) < MIN_DIM) begin
         r = CFG_W'(MIN_DIM);
      end else if (int'(v) > MAX_HEIGHT) begin
         r = CFG_W'(MAX_HEIGHT);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Frame geometry, held clamped.
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0]   height_ff, height_in;

   // Raster position of the next pixel.
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   // Last four accepted pixels, newest first.
   logic [PIX_W-1:0]   win_ff [LANES];
   logic [PIX_W-1:0]   win_in [LANES];

   // Line memory: one word per output column, one byte lane per row mod 4.
   logic [WORD_W-1:0]  line_mem [HALF];
   logic [WORD_W-1:0]  rd_ff;

   // Vertical stage: horizontal result plus the stored column.
   logic               s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]   s1_hv_ff;
   tap_kind_type       s1_vk_ff;
   logic [1:0]         s1_lane_ff;
   logic               s1_row_end_ff, s1_frame_end_ff;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   out_pixel_ff;
   logic               out_row_end_ff, out_frame_end_ff;

   logic               req_accept;
   logic               s1_adv;
   tap_kind_type       hk, vk;
   logic               col_last, row_last;
   logic [SLOT_W-1:0]  slot;
   logic [1:0]         lane;
   logic [PIX_W-1:0]   hv;
   logic [PIX_W-1:0]   vs [1:LANES];
   logic [PIX_W-1:0]   vout;

   // ---------------------------------------------------------------- handshake
   // Advance the vertical stage when the result register is empty or drains.
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------- horizontal pass
   assign hk       = classify(16'(col_ff), 16'(width_ff));
   assign vk       = classify(16'(row_ff), 16'(height_ff));
   assign col_last = (WIDTH_W'(col_ff) == width_ff - WIDTH_W'(1));
   assign row_last = (CFG_W'(row_ff) == height_ff - CFG_W'(1));
   assign lane     = row_ff[1:0];
   // Output column: the last tap always maps onto the final column.
   assign slot     = SLOT_W'(((hk == TAP_LAST_EVEN || hk == TAP_LAST_ODD)
                              ? (width_ff >> 1) : WIDTH_W'(col_ff >> 1))
                             - WIDTH_W'(1));
   assign hv       = filter5(hk, win_ff[3], win_ff[2], win_ff[1], win_ff[0], req_tdata);

   // ---------------------------------------------------------------- counters, window
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      for (int i = 0; i < LANES; i++) begin
         win_in[i] = win_ff[i];
      end
      if (req_accept) begin
         win_in[0] = req_tdata;
         for (int i = 1; i < LANES; i++) begin
            win_in[i] = win_ff[i-1];
         end
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      // A register write restarts the frame.
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
         unique case (csr_addr)
            CSR_IN_WIDTH:  width_in  = clamp_w(csr_wdata);
            CSR_IN_HEIGHT: height_in = clamp_h(csr_wdata);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_w(CFG_W'(IN_WIDTH_RST));
         height_ff <= clamp_h(CFG_W'(IN_HEIGHT_RST));
         col_ff    <= '0;
         row_ff    <= '0;
         for (int i = 0; i < LANES; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         for (int i = 0; i < LANES; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- line memory
   // Read before write: the lane of this row still holds the row four back.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= line_mem[slot];
         if (hk != TAP_NONE) begin
            line_mem[slot][lane*PIX_W +: PIX_W] <= hv;
         end
      end
   end

   // ---------------------------------------------------------------- vertical stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = (hk != TAP_NONE) && (vk != TAP_NONE);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_hv_ff        <= hv;
         s1_vk_ff        <= vk;
         s1_lane_ff      <= lane;
         s1_row_end_ff   <= col_last;
         s1_frame_end_ff <= col_last && row_last;
      end
   end

   // Rows one to four back sit in the lanes just below this row's lane; wrap the
   // lane number at two bits.
   always_comb begin
      for (int k = 1; k <= LANES; k++) begin
         vs[k] = rd_ff[2'(s1_lane_ff - 2'(k))*PIX_W +: PIX_W];
      end
   end

   assign vout = filter5(s1_vk_ff, vs[4], vs[3], vs[2], vs[1], s1_hv_ff);

   // ---------------------------------------------------------------- result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_pixel_ff     <= vout;
         out_row_end_ff   <= s1_row_end_ff;
         out_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_pixel_ff;
   assign rsp_tlast    = out_frame_end_ff;
   assign rsp_tuser[0] = out_row_end_ff;

   // ---------------------------------------------------------------- checks
   `GPR_ASSERT_IMP(a_frame_end_row_end, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser[0], "frame end without row end")
   `GPR_ASSERT_IMP(a_stall_cause, clock, reset, !req_tready, s1_valid_ff && out_valid_ff && !rsp_tready, "req stalled with room")
   `GPR_ASSERT_NXT(a_no_spurious, clock, reset, req_accept && hk == TAP_NONE, !s1_valid_ff, "result from a non-output column")
   `GPR_ASSERT_IMP(a_col_in_row, clock, reset, 1'b1, WIDTH_W'(col_ff) < width_ff, "column beyond row length")

endmodule
`default_nettype wire

@@ verif/gaussian_pyramid_reduce_top_tb.sv @@
module gaussian_pyramid_reduce_top_tb;

   localparam int HALF_ROW      = gpr_pkg::MAX_WIDTH_DEF / 2;
   localparam int STORE_SLOTS   = 4 * HALF_ROW;
   localparam int SETTLE_CYCLES = 4;     // result path is two stages deep, plus margin
   localparam int RANDOM_PIXELS = 450;
   localparam int IDLE_PCT      = 38;
   localparam int REPORT_LIMIT  = 10;

   // one reduced pixel as it leaves on rsp
   typedef struct packed {
      logic [gpr_pkg::PIX_W-1:0] pix;
      logic                      row_end;
      logic                      frame_end;
   } reduced_px_type;

   // one row of the directed table: a register write or a pixel transfer
   typedef struct packed {
      logic                        is_cfg;
      gpr_pkg::csr_index_type      addr;
      logic [gpr_pkg::CFG_W-1:0]   value;
      logic [gpr_pkg::PIX_W-1:0]   px;
      logic                        typed;    // expected result typed in below
      logic                        has_rsp;
      reduced_px_type              want;
   } dir_row_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [gpr_pkg::PIX_W-1:0]    req_tdata  = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [gpr_pkg::PIX_W-1:0]    rsp_tdata;
   logic                         rsp_tlast;
   logic [0:0]                   rsp_tuser;
   logic                         csr_we     = 1'b0;
   gpr_pkg::csr_index_type       csr_addr   = gpr_pkg::CSR_IN_WIDTH;
   logic [gpr_pkg::CFG_W-1:0]    csr_wdata  = '0;

   gaussian_pyramid_reduce_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Pyramid model: frame size registers, pixel window, counters and the
   // four-row store of horizontally filtered values.
   // ------------------------------------------------------------------
   logic [gpr_pkg::CFG_W-1:0]  pyr_width  = 12'(gpr_pkg::IN_WIDTH_RST);
   logic [gpr_pkg::CFG_W-1:0]  pyr_height = 12'(gpr_pkg::IN_HEIGHT_RST);
   logic [gpr_pkg::PIX_W-1:0]  pyr_window [4];
   int                         pyr_col = 0;
   int                         pyr_row = 0;
   logic [gpr_pkg::PIX_W-1:0]  pyr_store [STORE_SLOTS];

   reduced_px_type             reduced_q [$];   // reduced pixels still owed by the block
   int                         bad_count = 0;
   bit                         no_idle   = 1'b0;

   // values of the pixel now on req, for table rows with typed expectations
   logic                       cur_typed   = 1'b0;
   logic                       cur_has_rsp = 1'b0;
   reduced_px_type             cur_want    = '0;

   initial begin
      foreach (pyr_window[i]) pyr_window[i] = '0;
      foreach (pyr_store[i])  pyr_store[i]  = '0;
   end

   function automatic int clamp_size(logic [gpr_pkg::CFG_W-1:0] v, int hi);
      if (v < gpr_pkg::MIN_DIM) return gpr_pkg::MIN_DIM;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   // where a sample sits on the decimated grid of a row or a column
   function automatic gpr_pkg::tap_kind_type tap_at(int pos, int size);
      if (pos == size - 1) return (size % 2 == 1) ? gpr_pkg::TAP_LAST_ODD
                                                   : gpr_pkg::TAP_LAST_EVEN;
      if (pos == 2) return gpr_pkg::TAP_FIRST;
      if (pos % 2 == 0 && pos > 2 && pos <= 2 * (size / 2) - 2) return gpr_pkg::TAP_MID;
      return gpr_pkg::TAP_NONE;
   endfunction

   function automatic bit is_last_tap(gpr_pkg::tap_kind_type k);
      return k == gpr_pkg::TAP_LAST_EVEN || k == gpr_pkg::TAP_LAST_ODD;
   endfunction

   // 1-4-6-4-1 with the missing taps folded onto the center, then drop four bits
   function automatic logic [gpr_pkg::PIX_W-1:0] binomial_tap(gpr_pkg::tap_kind_type k,
                                                              int s4, int s3, int s2,
                                                              int s1, int cur);
      int sum;
      case (k)
         gpr_pkg::TAP_FIRST:     sum = 11 * s2 + 4 * s1 + cur;
         gpr_pkg::TAP_MID:       sum = s4 + 4 * s3 + 6 * s2 + 4 * s1 + cur;
         gpr_pkg::TAP_LAST_EVEN: sum = s3 + 4 * s2 + 11 * s1;
         default:                sum = s4 + 4 * s3 + 11 * s2;
      endcase
      return 8'(sum >> 4);
   endfunction

   // advance the model by one pixel; return 1 when it yields a reduced pixel
   function automatic bit reduce_pixel(input logic [gpr_pkg::PIX_W-1:0] px,
                                       output reduced_px_type res);
      int                         w, h, j, slot;
      int                         taps [1:4];
      gpr_pkg::tap_kind_type      hk, vk;
      logic [gpr_pkg::PIX_W-1:0]  hv;
      bit                         got;
      w   = clamp_size(pyr_width, gpr_pkg::MAX_WIDTH_DEF);
      h   = clamp_size(pyr_height, gpr_pkg::MAX_HEIGHT);
      hk  = tap_at(pyr_col, w);
      got = 1'b0;
      res = '0;
      if (hk != gpr_pkg::TAP_NONE) begin
         j    = is_last_tap(hk) ? w / 2 - 1 : pyr_col / 2 - 1;
         slot = j & (HALF_ROW - 1);
         hv   = binomial_tap(hk, pyr_window[3], pyr_window[2], pyr_window[1],
                             pyr_window[0], px);
         vk   = tap_at(pyr_row, h);
         if (vk != gpr_pkg::TAP_NONE) begin
            for (int k = 1; k <= 4; k++)
               taps[k] = pyr_store[((pyr_row - k) & 3) * HALF_ROW + slot];
            res.pix       = binomial_tap(vk, taps[4], taps[3], taps[2], taps[1], hv);
            res.row_end   = is_last_tap(hk);
            res.frame_end = is_last_tap(hk) && is_last_tap(vk);
            got           = 1'b1;
         end
         pyr_store[(pyr_row & 3) * HALF_ROW + slot] = hv;
      end
      pyr_window[3] = pyr_window[2];
      pyr_window[2] = pyr_window[1];
      pyr_window[1] = pyr_window[0];
      pyr_window[0] = px;
      pyr_col++;
      if (pyr_col >= w) begin
         pyr_col = 0;
         pyr_row++;
         if (pyr_row >= h) pyr_row = 0;
      end
      return got;
   endfunction

   task automatic note_bad(input string msg);
      bad_count++;
      if (bad_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------
   // Monitor: predict on every req transfer, check every rsp transfer.
   // Predict first so a same-edge result would still find its entry.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      reduced_px_type exp_px;
      reduced_px_type seen;
      bit             has;
      if (!reset) begin
         if (csr_we) begin
            case (csr_addr)
               gpr_pkg::CSR_IN_WIDTH:  pyr_width  = csr_wdata;
               gpr_pkg::CSR_IN_HEIGHT: pyr_height = csr_wdata;
               default: ;
            endcase
            // any write restarts the frame; window and store keep their contents
            pyr_col = 0;
            pyr_row = 0;
         end
         if (req_tvalid && req_tready) begin
            has = reduce_pixel(req_tdata, exp_px);
            if (cur_typed) begin
               has    = cur_has_rsp;
               exp_px = cur_want;
            end
            if (has) reduced_q.push_back(exp_px);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.pix       = rsp_tdata;
            seen.row_end   = rsp_tuser[0];
            seen.frame_end = rsp_tlast;
            if (reduced_q.size() == 0) begin
               note_bad($sformatf("unexpected pixel %0d row_end %0b frame_end %0b",
                                  seen.pix, seen.row_end, seen.frame_end));
            end else begin
               exp_px = reduced_q.pop_front();
               if (seen.pix !== exp_px.pix || seen.row_end !== exp_px.row_end ||
                   seen.frame_end !== exp_px.frame_end)
                  note_bad($sformatf({"pixel exp %0d got %0d, row_end exp %0b got %0b, ",
                                      "frame_end exp %0b got %0b"},
                                     exp_px.pix, seen.pix, exp_px.row_end, seen.row_end,
                                     exp_px.frame_end, seen.frame_end));
            end
         end
      end
   end

   // Sink side: stall about IDLE_PCT percent of cycles, never inside a burst window.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ------------------------------------------------------------------
   // Source side tasks. All of them start and end at a falling edge.
   // ------------------------------------------------------------------

   // Idle at random, then offer one pixel and hold it until the transfer.
   task automatic push_pixel(input logic [gpr_pkg::PIX_W-1:0] px, input logic typed,
                             input logic has_rsp, input reduced_px_type want);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tdata   <= px;
      cur_typed   = typed;
      cur_has_rsp = has_rsp;
      cur_want    = want;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed pixel has come out.
   task automatic hold_for_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (reduced_q.size() != 0) @(negedge clock);
   endtask

   // Write one register once the block is idle; pixels with no result may
   // still be in flight, so let the pipeline settle first.
   task automatic write_csr(input gpr_pkg::csr_index_type addr,
                            input logic [gpr_pkg::CFG_W-1:0] value);
      hold_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [gpr_pkg::PIX_W-1:0] rand_pixel();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) return 8'h00;
      if (pick < 10) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // Set the frame size (register order at random) and stream npix pixels.
   task automatic run_phase(input logic [gpr_pkg::CFG_W-1:0] wr,
                            input logic [gpr_pkg::CFG_W-1:0] hr,
                            input int npix, input bit burst, input int pause_at);
      if ($urandom_range(1) == 1) begin
         write_csr(gpr_pkg::CSR_IN_WIDTH, wr);
         write_csr(gpr_pkg::CSR_IN_HEIGHT, hr);
      end else begin
         write_csr(gpr_pkg::CSR_IN_HEIGHT, hr);
         write_csr(gpr_pkg::CSR_IN_WIDTH, wr);
      end
      no_idle = burst;
      for (int k = 0; k < npix; k++) begin
         if (k == pause_at) hold_for_drain();
         push_pixel(rand_pixel(), 1'b0, 1'b0, '0);
      end
      no_idle = 1'b0;
   endtask

   function automatic dir_row_type cfg_row(gpr_pkg::csr_index_type addr,
                                           logic [gpr_pkg::CFG_W-1:0] value);
      dir_row_type r;
      r        = '0;
      r.is_cfg = 1'b1;
      r.addr   = addr;
      r.value  = value;
      return r;
   endfunction

   function automatic dir_row_type px_row(logic [gpr_pkg::PIX_W-1:0] px, logic typed,
                                          logic has_rsp, logic [gpr_pkg::PIX_W-1:0] pix,
                                          logic row_end, logic frame_end);
      dir_row_type r;
      r                = '0;
      r.px             = px;
      r.typed          = typed;
      r.has_rsp        = has_rsp;
      r.want.pix       = pix;
      r.want.row_end   = row_end;
      r.want.frame_end = frame_end;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      dir_row_type dir_rows [$];
      dir_row_type row;
      int          sent, phase, ew, eh, npix, pause_at, pick;
      logic [gpr_pkg::CFG_W-1:0] wr, hr;

      // Directed 4x4 frame: two rows of white over two rows of black. Row 2
      // takes the first-row fold (11*255 + 4*255) >> 4 = 239, row 3 the
      // last-row fold (255 + 4*255) >> 4 = 79; column 3 is the last column.
      dir_rows.push_back(cfg_row(gpr_pkg::CSR_IN_WIDTH, 12'd4));
      dir_rows.push_back(cfg_row(gpr_pkg::CSR_IN_HEIGHT, 12'd4));
      //                        px     typed rsp  pix    re    fe
      dir_rows.push_back(px_row(8'hFF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'hFF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'hFF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'hFF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'hFF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'hFF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'hFF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'hFF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'h00, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'h00, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'h00, 1'b1, 1'b1, 8'd239, 1'b0, 1'b0));
      dir_rows.push_back(px_row(8'h00, 1'b1, 1'b1, 8'd239, 1'b1, 1'b0));
      dir_rows.push_back(px_row(8'h00, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'h00, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0));
      dir_rows.push_back(px_row(8'h00, 1'b1, 1'b1, 8'd79,  1'b0, 1'b0));
      dir_rows.push_back(px_row(8'h00, 1'b1, 1'b1, 8'd79,  1'b1, 1'b1));
      // sizes below four act as four; restart the frame and mix bit patterns
      dir_rows.push_back(cfg_row(gpr_pkg::CSR_IN_WIDTH, 12'd0));
      dir_rows.push_back(cfg_row(gpr_pkg::CSR_IN_HEIGHT, 12'd3));
      dir_rows.push_back(px_row(8'h01, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
      dir_rows.push_back(px_row(8'h80, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
      dir_rows.push_back(px_row(8'h7F, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
      dir_rows.push_back(px_row(8'hFE, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));

      // hold reset, then release it once
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_cfg) write_csr(row.addr, row.value);
         else push_pixel(row.px, row.typed, row.has_rsp, row.want);
      end

      // Random frames, mostly small and complete; some stop mid-frame so the
      // next register write restarts a partly streamed frame.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         pick = $urandom_range(99);
         wr   = (pick < 8) ? 12'($urandom_range(3))
              : (pick < 12) ? 12'd4 : 12'($urandom_range(4, 12));
         pick = $urandom_range(99);
         hr   = (pick < 8) ? 12'($urandom_range(3))
              : (pick < 12) ? 12'd4 : 12'($urandom_range(4, 8));
         ew   = clamp_size(wr, gpr_pkg::MAX_WIDTH_DEF);
         eh   = clamp_size(hr, gpr_pkg::MAX_HEIGHT);
         npix = ew * eh * $urandom_range(1, 2);
         if ($urandom_range(99) < 15) npix = $urandom_range(1, ew * eh - 1);
         // the first phase always pauses until the block has caught up
         pause_at = (phase == 0 || $urandom_range(99) < 20) ? $urandom_range(npix - 1) : -1;
         run_phase(wr, hr, npix, $urandom_range(99) < 10, pause_at);
         sent += npix;
         phase++;
      end

      // Size extremes, each a short run: tiny register values, the widest row
      // (streamed with no idling), widths and heights beyond the limit.
      run_phase(12'd3, 12'd0, 2 * 16, 1'b0, -1);
      run_phase(12'd2048, 12'd4, 96, 1'b1, -1);
      run_phase(12'd4095, 12'd5, 96, 1'b0, -1);
      run_phase(12'd4, 12'd4095, 128, 1'b0, -1);

      // drain, with a bound in case the block stops producing
      req_tvalid <= 1'b0;
      for (int t = 0; t < 5000 && reduced_q.size() != 0; t++) @(negedge clock);
      repeat (SETTLE_CYCLES * 2) @(negedge clock);

      if (bad_count == 0 && reduced_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/gpr_pkg.sv
sv/gaussian_pyramid_reduce_top.sv
verif/gaussian_pyramid_reduce_top_tb.sv
